// ----- design/rgba_box_downsample_2x2_macros.svh -----
// ----------------------------------------------------------------------------
// rgba_box_downsample_2x2 assertion macros
// Concurrent assertion wrappers on clk with synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef RGBA_BOX_DOWNSAMPLE_2X2_MACROS_SVH
`define RGBA_BOX_DOWNSAMPLE_2X2_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition at every rising clock edge outside reset
`define RBD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another one in the next cycle
`define RBD_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`else

`define RBD_ASSERT(name, prop, msg)
`define RBD_ASSERT_NEXT(name, pre, post, msg)

`endif

`endif

// ----- design/rbd_pkg.sv -----
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types, register indexes, reset values and channel arithmetic for
// the 2x2 box downsampler.
// ----------------------------------------------------------------------------
package rbd_pkg;

  // Field widths
  localparam int CH_W    = 8;
  localparam int SUM_W   = 9;
  localparam int SRC_W   = 13;
  localparam int DST_W   = 12;
  localparam int CFG_IDX_W = 2;

  // Default line capacity
  localparam int DEF_MAX_WIDTH = 4096;

  // Register reset values
  localparam logic [SRC_W-1:0] SRC_WIDTH_RST  = SRC_W'(256);
  localparam logic [SRC_W-1:0] SRC_HEIGHT_RST = SRC_W'(256);
  localparam logic [DST_W-1:0] DST_WIDTH_RST  = DST_W'(128);
  localparam logic [DST_W-1:0] DST_HEIGHT_RST = DST_W'(128);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH   = 2'd0,
    CFG_SRC_HEIGHT  = 2'd1,
    CFG_DEST_WIDTH  = 2'd2,
    CFG_DEST_HEIGHT = 2'd3
  } cfg_idx_t;

  // Four 9-bit channel sums of a column pair
  typedef struct packed {
    logic [SUM_W-1:0] alpha;
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
  } pair_sum_t;

  // Widen one pixel to pair-sum form
  function automatic pair_sum_t widen_px(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                         logic [CH_W-1:0] b, logic [CH_W-1:0] a);
    pair_sum_t p;
    p.red   = {1'b0, r};
    p.green = {1'b0, g};
    p.blue  = {1'b0, b};
    p.alpha = {1'b0, a};
    return p;
  endfunction

  // Per-channel add, each channel kept to 9 bits
  function automatic pair_sum_t add_pair(pair_sum_t x, pair_sum_t y);
    pair_sum_t s;
    s.red   = x.red + y.red;
    s.green = x.green + y.green;
    s.blue  = x.blue + y.blue;
    s.alpha = x.alpha + y.alpha;
    return s;
  endfunction

  // Truncated mean of two channel sums: divisor 1, 2 or 4
  function automatic logic [CH_W-1:0] mean_ch(logic [SUM_W-1:0] x, logic [SUM_W-1:0] y,
                                              logic [1:0] shift);
    logic [SUM_W:0] s;
    logic [SUM_W:0] q;
    s = {1'b0, x} + {1'b0, y};
    q = s >> shift;
    return q[CH_W-1:0];
  endfunction

endpackage

// ----- design/rgba_box_downsample_2x2.sv -----
// ----------------------------------------------------------------------------
// rgba_box_downsample_2x2
// Streams raster-order RGBA pixels and emits one truncated 2x2 mean per
// destination pixel, holding even-row pair sums in a line store.
// ----------------------------------------------------------------------------
// Path: the closing source pixel is registered in the input stage, with its line
//   store read at accept; the stage arithmetic then loads the output register.
// Throughput: 1 pixel per cycle, set by one line store read and one write
//   per cycle; output stalls back up through a one-entry stage.
// Reset: synchronous, active low; counters, pair sum and handshake clear,
//   registers return to 256x256 source, 128x128 destination.
`include "rgba_box_downsample_2x2_macros.svh"

module rgba_box_downsample_2x2 #(
  parameter int MAX_WIDTH = rbd_pkg::DEF_MAX_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbd_pkg::SRC_W-1:0]   cfg_data,
  // source pixels
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rbd_pkg::CH_W-1:0]    in_red,
  input  logic [rbd_pkg::CH_W-1:0]    in_green,
  input  logic [rbd_pkg::CH_W-1:0]    in_blue,
  input  logic [rbd_pkg::CH_W-1:0]    in_alpha,
  // destination pixels
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rbd_pkg::CH_W-1:0]    out_red,
  output logic [rbd_pkg::CH_W-1:0]    out_green,
  output logic [rbd_pkg::CH_W-1:0]    out_blue,
  output logic [rbd_pkg::CH_W-1:0]    out_alpha,
  output logic                        out_last_pixel
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int CLW = (CW + 1 > rbd_pkg::SRC_W) ? CW + 1 : rbd_pkg::SRC_W;
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int AW  = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  localparam logic [CLW-1:0] MAXW = CLW'(MAX_WIDTH);
  localparam logic [CLW-1:0] ONE  = CLW'(1);

  // Configuration registers
  logic [rbd_pkg::SRC_W-1:0] src_width_r, src_height_r;
  logic [rbd_pkg::DST_W-1:0] dest_width_r, dest_height_r;

  // Position counters
  logic [CW-1:0] col_cnt_r, row_cnt_r;

  // Input stage
  logic              s1_valid_r;
  logic [rbd_pkg::CH_W-1:0] s1_red_r, s1_green_r, s1_blue_r, s1_alpha_r;
  logic              s1_odd_col_r, s1_row_odd_r, s1_emit_r, s1_wr_r, s1_last_r;
  logic [AW-1:0]     s1_idx_r;

  // Pair accumulator and line store
  rbd_pkg::pair_sum_t acc_r;
  rbd_pkg::pair_sum_t line_mem [LINE_DEPTH];
  rbd_pkg::pair_sum_t rd_data_r, byp_data_r;
  logic               byp_r;

  // Output register
  logic              out_valid_r;
  logic [rbd_pkg::CH_W-1:0] out_red_r, out_green_r, out_blue_r, out_alpha_r;
  logic              out_last_r;

  // Position decode
  logic [CLW-1:0] src_w_ext, src_h_ext, sw, sh, half_w, half_h;
  logic [CLW-1:0] dst_w_ext, dst_h_ext, dw, dh;
  logic [CW-1:0]  col, row, dx, dy, col_nxt, row_nxt;
  logic           col_last, row_last, in_window, px_last, px_emit, px_wr;
  logic [AW-1:0]  rd_idx;

  // Handshake
  logic in_accept, s1_adv;

  // Stage arithmetic
  rbd_pkg::pair_sum_t px9, acc_nxt, line_sum, base;
  logic [1:0]         shift;
  logic               mem_we;

  // Clamp sizes
  always_comb begin
    src_w_ext = CLW'(src_width_r);
    src_h_ext = CLW'(src_height_r);
    sw = (src_w_ext == '0) ? ONE : ((src_w_ext > MAXW) ? MAXW : src_w_ext);
    sh = (src_h_ext == '0) ? ONE : ((src_h_ext > MAXW) ? MAXW : src_h_ext);
    half_w = (sw + ONE) >> 1;
    half_h = (sh + ONE) >> 1;
    dst_w_ext = CLW'(dest_width_r);
    dst_h_ext = CLW'(dest_height_r);
    dw = (dst_w_ext == '0) ? ONE : ((dst_w_ext > half_w) ? half_w : dst_w_ext);
    dh = (dst_h_ext == '0) ? ONE : ((dst_h_ext > half_h) ? half_h : dst_h_ext);
  end

  // Decode the position of the incoming pixel
  always_comb begin
    col = (CLW'(col_cnt_r) >= sw) ? '0 : col_cnt_r;
    row = (CLW'(row_cnt_r) >= sh) ? '0 : row_cnt_r;
    dx  = col >> 1;
    dy  = row >> 1;
    col_last  = (CLW'(col) + ONE >= sw);
    row_last  = (CLW'(row) + ONE >= sh);
    in_window = (col[0] || col_last) && (CLW'(dx) < dw) && (CLW'(dy) < dh);
    px_last   = (CLW'(dx) == dw - ONE) && (CLW'(dy) == dh - ONE);
    px_wr     = in_window && !row[0] && !row_last;
    px_emit   = in_window && (row[0] || row_last);
    rd_idx    = AW'(dx);
    col_nxt   = col_last ? '0 : col + CW'(1);
    row_nxt   = col_last ? (row_last ? '0 : row + CW'(1)) : row;
  end

  // Handshake: advance the input stage whenever the output slot frees
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_accept = in_valid && in_ready;

  // Pair sum, line store operand and divisor
  always_comb begin
    px9      = rbd_pkg::widen_px(s1_red_r, s1_green_r, s1_blue_r, s1_alpha_r);
    acc_nxt  = s1_odd_col_r ? rbd_pkg::add_pair(acc_r, px9) : px9;
    line_sum = byp_r ? byp_data_r : rd_data_r;
    base     = s1_row_odd_r ? line_sum : '0;
    shift    = {1'b0, s1_odd_col_r} + {1'b0, s1_row_odd_r};
    mem_we   = s1_adv && s1_wr_r;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r   <= rbd_pkg::SRC_WIDTH_RST;
      src_height_r  <= rbd_pkg::SRC_HEIGHT_RST;
      dest_width_r  <= rbd_pkg::DST_WIDTH_RST;
      dest_height_r <= rbd_pkg::DST_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (rbd_pkg::cfg_idx_t'(cfg_index))
        rbd_pkg::CFG_SRC_WIDTH:   src_width_r   <= cfg_data;
        rbd_pkg::CFG_SRC_HEIGHT:  src_height_r  <= cfg_data;
        rbd_pkg::CFG_DEST_WIDTH:  dest_width_r  <= cfg_data[rbd_pkg::DST_W-1:0];
        rbd_pkg::CFG_DEST_HEIGHT: dest_height_r <= cfg_data[rbd_pkg::DST_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance counters and the input stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        col_cnt_r <= col_nxt;
        row_cnt_r <= row_nxt;
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // Capture the request payload and its decoded position
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_red_r     <= in_red;
      s1_green_r   <= in_green;
      s1_blue_r    <= in_blue;
      s1_alpha_r   <= in_alpha;
      s1_odd_col_r <= col[0];
      s1_row_odd_r <= row[0];
      s1_emit_r    <= px_emit;
      s1_wr_r      <= px_wr;
      s1_last_r    <= px_last;
      s1_idx_r     <= rd_idx;
    end
  end

  // Line store: write from the input stage, read for the accepted pixel
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[s1_idx_r] <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_data_r  <= line_mem[rd_idx];
      byp_r      <= mem_we && (s1_idx_r == rd_idx);
      byp_data_r <= acc_nxt;
    end
  end

  // Hold the running column pair sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (s1_adv) begin
      acc_r <= acc_nxt;
    end
  end

  // Output register: load on a result, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_emit_r;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit_r) begin
      out_red_r   <= rbd_pkg::mean_ch(base.red,   acc_nxt.red,   shift);
      out_green_r <= rbd_pkg::mean_ch(base.green, acc_nxt.green, shift);
      out_blue_r  <= rbd_pkg::mean_ch(base.blue,  acc_nxt.blue,  shift);
      out_alpha_r <= rbd_pkg::mean_ch(base.alpha, acc_nxt.alpha, shift);
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = out_red_r;
  assign out_green      = out_green_r;
  assign out_blue       = out_blue_r;
  assign out_alpha      = out_alpha_r;
  assign out_last_pixel = out_last_r;

  // Assertions
  `RBD_ASSERT(a_no_accept_when_blocked,
              !(s1_valid_r && out_valid_r && !out_ready && in_ready),
              "input accepted while both stages are blocked")
  `RBD_ASSERT(a_emit_wr_exclusive,
              !(s1_valid_r && s1_emit_r && s1_wr_r),
              "pixel both stores and emits")
  `RBD_ASSERT(a_store_even_row,
              !(mem_we && s1_row_odd_r),
              "line store written on an odd row")
  `RBD_ASSERT_NEXT(a_result_loaded,
                   s1_adv && s1_emit_r,
                   out_valid_r,
                   "result lost on its way out")

endmodule

// ----- tb/rgba_box_downsample_2x2_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgba_box_downsample_2x2_tb
// Streams RGBA images through the 2x2 box downsampler and checks every
// destination pixel against a cycle-free software copy of the filter: edge
// windows, clamped sizes, mid-image resizes, size extremes and random images
// with random stalls on both channels.
// ----------------------------------------------------------------------------
module rgba_box_downsample_2x2_tb;

  localparam int MAX_W         = rbd_pkg::DEF_MAX_WIDTH;
  localparam int LINE_DEPTH    = (MAX_W + 1) / 2;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PIXELS = 1400;
  localparam int IDLE_PCT      = 38;
  localparam int MAX_REPORTS   = 10;
  localparam int TIMEOUT_NS    = 5_000_000;

  // Four 9-bit channel sums
  typedef struct packed {
    logic [8:0] alpha;
    logic [8:0] blue;
    logic [8:0] green;
    logic [8:0] red;
  } chan_sums_t;

  // One destination pixel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } dest_px_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  rbd_pkg::cfg_idx_t cfg_index = rbd_pkg::CFG_SRC_WIDTH;
  logic [12:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_red = '0;
  logic [7:0] in_green = '0;
  logic [7:0] in_blue = '0;
  logic [7:0] in_alpha = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic       out_last_pixel;

  // Filter state mirrored by the predictor
  logic [12:0] geo_src_w = rbd_pkg::SRC_WIDTH_RST;
  logic [12:0] geo_src_h = rbd_pkg::SRC_HEIGHT_RST;
  logic [11:0] geo_dst_w = rbd_pkg::DST_WIDTH_RST;
  logic [11:0] geo_dst_h = rbd_pkg::DST_HEIGHT_RST;
  chan_sums_t  pair_acc = '0;
  chan_sums_t  row_pair_sums [LINE_DEPTH];
  int          col_cnt = 0;
  int          row_cnt = 0;

  dest_px_t    dest_q [$];
  dest_px_t    want_px;
  dest_px_t    got_px;
  bit          idle_en = 1'b1;
  int          fail_cnt = 0;
  int          px_sent = 0;
  int          results_seen = 0;
  int          images_done = 0;
  int          reg_writes = 0;

  rgba_box_downsample_2x2 DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .in_alpha      (in_alpha),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha     (out_alpha),
    .out_last_pixel(out_last_pixel)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_ready <= !(idle_en && ($urandom_range(99) < IDLE_PCT));
  end

  function automatic int fit_range(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Per-channel add, wrapped to 9 bits
  function automatic chan_sums_t add_sums(chan_sums_t x, chan_sums_t y);
    chan_sums_t s;
    s.red   = x.red + y.red;
    s.green = x.green + y.green;
    s.blue  = x.blue + y.blue;
    s.alpha = x.alpha + y.alpha;
    return s;
  endfunction

  function automatic logic [7:0] chan_mean(logic [8:0] x, logic [8:0] y, int shift);
    logic [9:0] s;
    s = x + y;
    s = s >> shift;
    return s[7:0];
  endfunction

  // Combine two pair sums into one destination pixel
  function automatic dest_px_t window_mean(chan_sums_t x, chan_sums_t y, int shift, bit last);
    dest_px_t d;
    d.red   = chan_mean(x.red, y.red, shift);
    d.green = chan_mean(x.green, y.green, shift);
    d.blue  = chan_mean(x.blue, y.blue, shift);
    d.alpha = chan_mean(x.alpha, y.alpha, shift);
    d.last  = last;
    return d;
  endfunction

  // Append one expected destination pixel
  function automatic void queue_expected(dest_px_t d);
    dest_q.insert(dest_q.size(), d);
  endfunction

  function automatic void note_error(string msg);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  // Advance the filter by one source pixel and queue any destination pixel
  task automatic predict_pixel(input logic [7:0] r, g, b, a);
    int sw, sh, dw, dh, col, row, dx, dy, shift;
    bit last;
    chan_sums_t px;
    sw = fit_range(int'(geo_src_w), MAX_W);
    sh = fit_range(int'(geo_src_h), MAX_W);
    dw = fit_range(int'(geo_dst_w), (sw + 1) / 2);
    dh = fit_range(int'(geo_dst_h), (sh + 1) / 2);
    if (col_cnt >= sw) col_cnt = 0;
    if (row_cnt >= sh) row_cnt = 0;
    col = col_cnt;
    row = row_cnt;
    dx = col / 2;
    dy = row / 2;
    px.red   = {1'b0, r};
    px.green = {1'b0, g};
    px.blue  = {1'b0, b};
    px.alpha = {1'b0, a};
    if (col % 2 == 0) pair_acc = px;
    else pair_acc = add_sums(pair_acc, px);
    // Close a window column pair inside the destination footprint
    if ((col % 2 == 1 || col + 1 >= sw) && dx < dw && dy < dh) begin
      shift = col % 2;
      last = (dx == dw - 1) && (dy == dh - 1);
      if (row % 2 == 0) begin
        if (row + 1 < sh) row_pair_sums[dx % LINE_DEPTH] = pair_acc;
        else queue_expected(window_mean(pair_acc, '0, shift, last));
      end else begin
        queue_expected(window_mean(row_pair_sums[dx % LINE_DEPTH], pair_acc,
                                   shift + 1, last));
      end
    end
    if (col + 1 >= sw) begin
      col_cnt = 0;
      row_cnt = (row + 1 >= sh) ? 0 : row + 1;
    end else begin
      col_cnt = col + 1;
    end
  endtask

  // Offer one pixel request, idling first at random; entered and left at a falling edge
  task automatic send_pixel(input logic [7:0] r, g, b, a);
    while (idle_en && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    in_alpha <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pixel(r, g, b, a);
    px_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_pixels(input int n);
    repeat (n) begin
      send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)));
    end
  endtask

  // Send pixels until the image wraps back to its first pixel
  task automatic finish_image();
    do begin
      send_random_pixels(1);
    end while (!(col_cnt == 0 && row_cnt == 0));
    images_done++;
  endtask

  // Drop valid, wait for every expected pixel, then let the pipeline empty
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (dest_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input rbd_pkg::cfg_idx_t idx, input logic [12:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    case (idx)
      rbd_pkg::CFG_SRC_WIDTH:   geo_src_w = val;
      rbd_pkg::CFG_SRC_HEIGHT:  geo_src_h = val;
      rbd_pkg::CFG_DEST_WIDTH:  geo_dst_w = val[11:0];
      rbd_pkg::CFG_DEST_HEIGHT: geo_dst_h = val[11:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_geometry(input logic [12:0] sw, sh, dw, dh);
    drain_and_settle();
    write_reg(rbd_pkg::CFG_SRC_WIDTH, sw);
    write_reg(rbd_pkg::CFG_SRC_HEIGHT, sh);
    write_reg(rbd_pkg::CFG_DEST_WIDTH, dw);
    write_reg(rbd_pkg::CFG_DEST_HEIGHT, dh);
  endtask

  // Odd-sized image: full, right-edge, bottom-edge and corner windows
  task automatic test_edge_windows();
    set_geometry(13'd3, 13'd3, 13'd2, 13'd2);
    for (int i = 0; i < 9; i++) begin
      send_pixel(8'hFF, 8'h00, (i % 2 == 1) ? 8'hFF : 8'h00, 8'($urandom_range(255)));
    end
    images_done++;
  endtask

  // Zero and small destination sizes: extra columns and rows pass silently
  task automatic test_clamped_dest();
    set_geometry(13'd3, 13'd3, 13'd0, 13'd1);
    finish_image();
  endtask

  // Shrink the width, then the height, in the middle of an image
  task automatic test_resize_mid_image();
    set_geometry(13'd8, 13'd4, 13'd4, 13'd2);
    send_random_pixels(5);
    drain_and_settle();
    write_reg(rbd_pkg::CFG_SRC_WIDTH, 13'd4);
    send_random_pixels(9);
    drain_and_settle();
    write_reg(rbd_pkg::CFG_SRC_HEIGHT, 13'd2);
    finish_image();
  endtask

  // Oversize destinations, single-column, single-row and zero-size images
  task automatic test_size_extremes();
    set_geometry(13'd13, 13'd3, 13'hFFF, 13'hFFF);
    finish_image();
    set_geometry(13'd1, 13'd9, 13'd1, 13'hFFF);
    finish_image();
    set_geometry(13'd9, 13'd1, 13'hFFF, 13'd0);
    finish_image();
    set_geometry(13'd0, 13'd0, 13'd0, 13'd0);
    finish_image();
  endtask

  function automatic logic [12:0] pick_dest(int s);
    case ($urandom_range(3))
      0: return 13'(s / 2);
      1: return 13'((s + 1) / 2);
      2: return 13'($urandom_range(0, (s + 1) / 2 + 2));
      default: return 13'($urandom_range(0, 8191));
    endcase
  endfunction

  task automatic random_geometry();
    int sw, sh;
    sw = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 12);
    sh = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 8);
    set_geometry(13'(sw), 13'(sh), pick_dest(sw), pick_dest(sh));
  endtask

  // Random small images, some resized part way through
  task automatic test_random_images();
    int start, total;
    start = px_sent;
    while (px_sent - start < RANDOM_PIXELS) begin
      idle_en = !((px_sent - start >= 500) && (px_sent - start < 900));
      random_geometry();
      total = fit_range(int'(geo_src_w), MAX_W) * fit_range(int'(geo_src_h), MAX_W);
      if (total > 1 && $urandom_range(99) < 15) begin
        send_random_pixels($urandom_range(1, total - 1));
        random_geometry();
      end
      finish_image();
    end
    idle_en = 1'b1;
  endtask

  // Check each accepted destination pixel against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_px = '{out_red, out_green, out_blue, out_alpha, out_last_pixel};
      results_seen++;
      if (dest_q.size() == 0) begin
        note_error($sformatf("unexpected pixel r=%02x g=%02x b=%02x a=%02x last=%0b",
                             got_px.red, got_px.green, got_px.blue, got_px.alpha,
                             got_px.last));
      end else begin
        want_px = dest_q.pop_front();
        if (got_px.red !== want_px.red || got_px.green !== want_px.green ||
            got_px.blue !== want_px.blue || got_px.alpha !== want_px.alpha ||
            got_px.last !== want_px.last) begin
          note_error($sformatf({"pixel %0d: expected r=%02x g=%02x b=%02x a=%02x last=%0b,",
                                " got r=%02x g=%02x b=%02x a=%02x last=%0b"},
                               results_seen, want_px.red, want_px.green, want_px.blue,
                               want_px.alpha, want_px.last, got_px.red, got_px.green,
                               got_px.blue, got_px.alpha, got_px.last));
        end
      end
    end
  end

  // Hard limit on run time
  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_edge_windows();
    test_clamped_dest();
    test_resize_mid_image();
    test_size_extremes();
    test_random_images();
    drain_and_settle();
    $display("Sent %0d source pixels in %0d images with %0d register writes.",
             px_sent, images_done, reg_writes);
    $display("Checked %0d destination pixels, %0d failures.", results_seen, fail_cnt);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
